// File: rtl/prs_pkg.sv
// package for the periodic report scheduler
// holds request, report and table entry types, state codes and default sizes
// no dependencies
package prs_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 20;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] var_id;
        logic [15:0] period;
    } t_req;

    typedef struct packed {
        logic [15:0] report_id;
        logic        periodic;
    } t_rpt;

    typedef struct packed {
        logic        enable;
        logic [15:0] var_id;
        logic [15:0] period;
        logic [15:0] timer;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/prs_ram.sv
// generic simple dual port ram with registered read
// one write port and one read port, no dependencies
module prs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/prs_scan.sv
// table walker of the periodic report scheduler
// reads one entry per cycle and, for a tick or a matching request, writes it back updated; uses prs_pkg
// drives the report strobe and payload
module prs_scan
    import prs_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_req          i_req,
    output logic          o_busy,
    output logic          o_valid,
    output t_rpt          o_rpt,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_entry        i_rd_entry,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_entry        o_wr_entry
);

    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [AW-1:0] r_free_idx, n_free_idx;
    logic [15:0]   r_free_timer, n_free_timer;
    logic          r_hit, n_hit;
    logic [15:0]   r_hit_id, n_hit_id;
    logic          r_out_valid, n_out_valid;
    t_rpt          r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_free_idx   <= n_free_idx;
        r_free_timer <= n_free_timer;
        r_hit_id     <= n_hit_id;
        r_out        <= n_out;
    end

    always_comb begin
        logic [15:0] v_inc;
        logic        v_match;
        logic        v_due;
        logic        v_stop;
        logic        v_finish;
        logic        v_is_req;

        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_found      = r_found;
        n_free_idx   = r_free_idx;
        n_free_timer = r_free_timer;
        n_hit        = r_hit;
        n_hit_id     = r_hit_id;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_idx;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_idx;
        o_wr_entry   = i_rd_entry;

        v_inc    = i_rd_entry.timer + 16'd1;
        v_match  = (i_rd_entry.var_id == r_req.var_id);
        v_is_req = (r_req.kind == KIND_REQUEST);
        v_due    = 1'b0;
        v_stop   = 1'b0;
        v_finish = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req     = i_req;
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_hit     = 1'b0;
                    o_rd_en   = 1'b1;
                    o_rd_addr = '0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (v_is_req) begin
                    if (v_match) begin
                        o_wr_en           = 1'b1;
                        o_wr_entry.period = r_req.period;
                        o_wr_entry.enable = (r_req.period != 16'd0);
                        v_stop            = (r_req.period != 16'd0);
                    end else if (!i_rd_entry.enable && !r_found) begin
                        n_found      = 1'b1;
                        n_free_idx   = r_idx;
                        n_free_timer = i_rd_entry.timer;
                    end
                end else begin
                    v_due = i_rd_entry.enable && (i_rd_entry.period != 16'd0)
                            && (v_inc >= i_rd_entry.period) && !r_hit;
                    o_wr_en          = 1'b1;
                    o_wr_entry.timer = v_due ? 16'd0 : v_inc;
                    if (v_due) begin
                        n_hit    = 1'b1;
                        n_hit_id = i_rd_entry.var_id;
                    end
                end
                if (v_stop) begin
                    v_finish = 1'b1;
                end else if (r_idx == LAST_IDX) begin
                    if (v_is_req && (r_req.period != 16'd0)) begin
                        n_state = ST_FILL;
                    end else begin
                        v_finish = 1'b1;
                    end
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            ST_FILL: begin
                o_wr_en    = r_found;
                o_wr_addr  = r_free_idx;
                o_wr_entry = '{enable: 1'b1, var_id: r_req.var_id,
                               period: r_req.period, timer: r_free_timer};
                v_finish   = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (v_finish) begin
            n_state         = ST_IDLE;
            n_out_valid     = v_is_req || n_hit;
            n_out.report_id = v_is_req ? r_req.var_id : n_hit_id;
            n_out.periodic  = !v_is_req;
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_rpt   = r_out;

endmodule

// File: rtl/periodic_report_scheduler_unit.sv
// top level of the periodic report scheduler
// holds the entry table ram, its per-entry valid bits and the table walker
// depends on prs_pkg, prs_ram and prs_scan
//
// An item is taken when start is high and busy is low. Every item walks the
// table at most once through the single read port of the entry memory, one
// entry per cycle. A tick, or a request that cancels, walks the whole table; a
// request with a nonzero period that finds its id stops at that entry; a request
// that fills or finds the table full walks it all, then passes the fill state.
// The report appears on o_rpt with o_valid high for one cycle right after busy
// falls, and a new item may be started in that same cycle. Requests always
// report once with periodic low; a tick reports at most one due entry with
// periodic high. The receiver cannot stall the strobe. After reset the table
// reads as all zero at once through per-entry valid bits, with no clearing pass.
module periodic_report_scheduler_unit
    import prs_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rpt o_rpt
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_entry;
    t_entry             rd_entry;
    logic [ENTRY_W-1:0] ram_q;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                     r_rd_ok;

    prs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_valid[rd_addr];
            end
        end
    end

    assign rd_entry = r_rd_ok ? t_entry'(ram_q) : '0;

    prs_scan #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_rpt      (o_rpt),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_entry (rd_entry),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_entry (wr_entry)
    );

`ifndef SYNTHESIS
    a_one_report_per_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("report strobe on two cycles in a row");

    a_start_sets_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start a table walk");

    a_write_only_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> busy)
        else $error("table write outside a walk");

    a_no_rw_collision : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write of the same entry in one cycle");
`endif

endmodule
